// ----- hdl/bpli_pkg.sv -----
// Shared types, widths and constants for the band port and loss interpolator.
// Depends on nothing; every other file but bpli_ram refers to it, by scoped names or by import.
`timescale 1ns / 1ps

package bpli_pkg;

    // Table geometry
    localparam int CHAIN_COUNT      = 4;
    localparam int POINTS_PER_CHAIN = 16;
    localparam int BAND_COUNT       = 3;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CHAIN_W  = 2;
    localparam int IDX_W    = 4;
    localparam int CNT_IN_W = 5;
    localparam int BAND_W   = 2;
    localparam int FREQ_W   = 13;
    localparam int LOSS_W   = 16;
    localparam int PORT_W   = 4;

    // Derived storage sizes
    localparam int PT_DEPTH    = CHAIN_COUNT * POINTS_PER_CHAIN;
    localparam int ADDR_W      = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int CNT_W       = $clog2(POINTS_PER_CHAIN + 1);
    localparam int CHAIN_IDX_W = (CHAIN_COUNT > 1) ? $clog2(CHAIN_COUNT) : 1;
    localparam int PMAP_DEPTH  = CHAIN_COUNT * BAND_COUNT;
    localparam int PMAP_W      = $clog2(PMAP_DEPTH);

    // Interpolation arithmetic
    localparam int DIFF_W    = LOSS_W + 1;
    localparam int PROD_W    = FREQ_W + DIFF_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_POINT = 2'd0,
        CMD_SET_COUNT   = 2'd1,
        CMD_WRITE_PORTS = 2'd2,
        CMD_LOOKUP      = 2'd3
    } cmd_t;

    typedef enum logic [BAND_W-1:0] {
        BAND_24G = 2'd0,
        BAND_5G  = 2'd1,
        BAND_6G  = 2'd2
    } band_t;

    localparam logic [FREQ_W-1:0]        EDGE_24G_MHZ    = 13'd2484;
    localparam logic [FREQ_W-1:0]        EDGE_5G_LOW_MHZ = 13'd4900;
    localparam logic [FREQ_W-1:0]        EDGE_6G_MHZ     = 13'd6000;
    localparam logic signed [LOSS_W-1:0] LOSS_ONE        = 16'sd256;
    localparam logic [PORT_W-1:0]        PORT_RESET      = 4'd1;

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [LOSS_W-1:0] loss;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [FREQ_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hdl/bpli_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
// Depends on bpli_pkg for field widths.
`timescale 1ns / 1ps

interface bpli_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpli_pkg::CMD_W-1:0]    command;
    logic [bpli_pkg::CHAIN_W-1:0]  chain;
    logic [bpli_pkg::IDX_W-1:0]    point_index;
    logic [bpli_pkg::CNT_IN_W-1:0] point_count;
    logic [bpli_pkg::BAND_W-1:0]   band;
    logic [bpli_pkg::FREQ_W-1:0]   freq_mhz;
    logic signed [bpli_pkg::LOSS_W-1:0] loss_value;
    logic [bpli_pkg::PORT_W-1:0]   vsa_port;
    logic [bpli_pkg::PORT_W-1:0]   vsg_port;

    modport source (
        output valid, command, chain, point_index, point_count, band,
               freq_mhz, loss_value, vsa_port, vsg_port,
        input  ready
    );
    modport sink (
        input  valid, command, chain, point_index, point_count, band,
               freq_mhz, loss_value, vsa_port, vsg_port,
        output ready
    );
endinterface

interface bpli_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpli_pkg::LOSS_W-1:0] loss_out;
    logic [bpli_pkg::PORT_W-1:0]        vsa_out;
    logic [bpli_pkg::PORT_W-1:0]        vsg_out;
    logic                               band_hit;

    modport source (
        output valid, loss_out, vsa_out, vsg_out, band_hit,
        input  ready
    );
    modport sink (
        input  valid, loss_out, vsa_out, vsg_out, band_hit,
        output ready
    );
endinterface

// ----- hdl/bpli_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; width and depth are set by the instantiating module.
`timescale 1ns / 1ps

module bpli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bpli_div.sv -----
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on bpli_pkg for the request/response structs and widths.
`timescale 1ns / 1ps

module bpli_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bpli_pkg::div_req_t req,
    output bpli_pkg::div_rsp_t rsp
);

    logic                               busy_reg,  busy_next;
    logic                               done_reg,  done_next;
    logic [bpli_pkg::DIV_CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [bpli_pkg::FREQ_W-1:0]        rem_reg,   rem_next;
    logic [bpli_pkg::PROD_W-1:0]        quo_reg,   quo_next;
    logic [bpli_pkg::FREQ_W-1:0]        dsr_reg,   dsr_next;

    logic [bpli_pkg::FREQ_W:0]          rem_sh;
    logic [bpli_pkg::FREQ_W+1:0]        diff;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[bpli_pkg::PROD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = bpli_pkg::DIV_CNT_W'(bpli_pkg::PROD_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[bpli_pkg::FREQ_W+1])
            begin
                rem_next = diff[bpli_pkg::FREQ_W-1:0];
                quo_next = {quo_reg[bpli_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[bpli_pkg::FREQ_W-1:0];
                quo_next = {quo_reg[bpli_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            // Finish on the last quotient bit
            if (cnt_reg == bpli_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- hdl/band_port_and_loss_interpolator.sv -----
// Top level: command decode, table storage, lookup sequencer and result register.
// Depends on bpli_pkg, bpli_if, bpli_ram and bpli_div.
//
// Usage: commands arrive on the req channel (valid/ready); only a lookup
// produces a transaction on the rsp channel. Write point, set count and
// write ports take effect in the accepting cycle and the block is ready
// again in the next cycle.
// A lookup holds req.ready low while the sequencer walks the chain's table
// one point per cycle through the point RAM's single registered read port:
// the first and last points, then up to POINTS_PER_CHAIN - 1 segments,
// and on a hit between points a multiply step and the serial divider.
// req.ready rises again together with rsp.valid for the result, so the
// next command can be taken while the result is presented.
// The result waits in an output register; a new command is taken while it
// waits, and a lookup that finishes while it is still held stalls in its
// final step until rsp.ready frees the register.
// Reset clears the point counts and sets every band port to 1; the point
// RAM is not cleared and a point must be written before a lookup reads it.
`timescale 1ns / 1ps

module band_port_and_loss_interpolator (
    input  logic            clk,
    input  logic            rst_n,
    bpli_req_if.sink        req,
    bpli_rsp_if.source      rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    // Sequencer state
    state_t                               state_reg,     state_next;
    logic [bpli_pkg::FREQ_W-1:0]          freq_reg,      freq_next;
    logic [bpli_pkg::CNT_W-1:0]           cnt_reg,       cnt_next;
    logic [bpli_pkg::CNT_W-1:0]           j_reg,         j_next;
    logic [bpli_pkg::ADDR_W-1:0]          base_reg,      base_next;
    logic [bpli_pkg::FREQ_W-1:0]          prev_freq_reg, prev_freq_next;
    logic signed [bpli_pkg::LOSS_W-1:0]   prev_loss_reg, prev_loss_next;
    logic [bpli_pkg::FREQ_W-1:0]          df_reg,        df_next;
    logic [bpli_pkg::FREQ_W-1:0]          dden_reg,      dden_next;
    logic signed [bpli_pkg::DIFF_W-1:0]   dl_reg,        dl_next;
    logic signed [bpli_pkg::PROD_W-1:0]   prod_reg,      prod_next;
    logic signed [bpli_pkg::LOSS_W-1:0]   loss_res_reg,  loss_res_next;
    logic [bpli_pkg::PORT_W-1:0]          vsa_res_reg,   vsa_res_next;
    logic [bpli_pkg::PORT_W-1:0]          vsg_res_reg,   vsg_res_next;
    logic                                 hit_res_reg,   hit_res_next;

    // Result register
    logic                                 out_valid_reg, out_valid_next;
    logic signed [bpli_pkg::LOSS_W-1:0]   out_loss_reg,  out_loss_next;
    logic [bpli_pkg::PORT_W-1:0]          out_vsa_reg,   out_vsa_next;
    logic [bpli_pkg::PORT_W-1:0]          out_vsg_reg,   out_vsg_next;
    logic                                 out_hit_reg,   out_hit_next;

    // Tables held in flip-flops
    logic [bpli_pkg::CNT_W-1:0]  count_reg [bpli_pkg::CHAIN_COUNT];
    logic [bpli_pkg::PORT_W-1:0] vsa_map_reg [bpli_pkg::PMAP_DEPTH];
    logic [bpli_pkg::PORT_W-1:0] vsg_map_reg [bpli_pkg::PMAP_DEPTH];

    // Request decode
    logic                             req_fire;
    logic                             chain_ok;
    logic [bpli_pkg::CHAIN_IDX_W-1:0] chain_idx;
    logic [bpli_pkg::PMAP_W-1:0]      wr_pmap_idx;
    logic [bpli_pkg::PMAP_W-1:0]      rd_pmap_idx;
    logic                             band_hit;
    bpli_pkg::band_t                  band_sel;
    logic [bpli_pkg::CNT_W-1:0]       sat_count;
    logic [bpli_pkg::ADDR_W-1:0]      req_base;

    // Point RAM ports
    logic                             pt_we;
    logic [bpli_pkg::ADDR_W-1:0]      pt_waddr;
    logic [bpli_pkg::ADDR_W-1:0]      pt_raddr;
    bpli_pkg::point_t                 pt_wdata;
    bpli_pkg::point_t                 pt_rdata;
    logic [bpli_pkg::POINT_W-1:0]     pt_rword;

    // Divider link
    bpli_pkg::div_req_t               div_req;
    bpli_pkg::div_rsp_t               div_rsp;
    logic [bpli_pkg::DIFF_W-1:0]      quo_mag;
    logic signed [bpli_pkg::DIFF_W-1:0] quo_signed;
    logic signed [bpli_pkg::DIFF_W-1:0] loss_sum;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign chain_ok  = (int'(req.chain) < bpli_pkg::CHAIN_COUNT);
    assign chain_idx = bpli_pkg::CHAIN_IDX_W'(req.chain);
    assign req_base  = bpli_pkg::ADDR_W'(int'(req.chain) * bpli_pkg::POINTS_PER_CHAIN);

    // Saturate the requested point count at the table size
    assign sat_count = (int'(req.point_count) > bpli_pkg::POINTS_PER_CHAIN) ?
                       bpli_pkg::CNT_W'(bpli_pkg::POINTS_PER_CHAIN) :
                       bpli_pkg::CNT_W'(req.point_count);

    // Pick the band of the request frequency
    always_comb
    begin
        band_hit = 1'b0;
        band_sel = bpli_pkg::BAND_24G;
        if (req.freq_mhz <= bpli_pkg::EDGE_24G_MHZ)
        begin
            band_hit = 1'b1;
            band_sel = bpli_pkg::BAND_24G;
        end
        else if ((req.freq_mhz > bpli_pkg::EDGE_5G_LOW_MHZ) &&
                 (req.freq_mhz < bpli_pkg::EDGE_6G_MHZ))
        begin
            band_hit = 1'b1;
            band_sel = bpli_pkg::BAND_5G;
        end
        else if (req.freq_mhz >= bpli_pkg::EDGE_6G_MHZ)
        begin
            band_hit = 1'b1;
            band_sel = bpli_pkg::BAND_6G;
        end
    end

    assign wr_pmap_idx = bpli_pkg::PMAP_W'(int'(req.chain) * bpli_pkg::BAND_COUNT +
                                           int'(req.band));
    assign rd_pmap_idx = bpli_pkg::PMAP_W'(int'(req.chain) * bpli_pkg::BAND_COUNT +
                                           int'(band_sel));

    // Point RAM write straight from an accepted write point command
    assign pt_we = req_fire && (req.command == bpli_pkg::CMD_WRITE_POINT) && chain_ok &&
                   (int'(req.point_index) < bpli_pkg::POINTS_PER_CHAIN);
    assign pt_waddr      = bpli_pkg::ADDR_W'(int'(req.chain) * bpli_pkg::POINTS_PER_CHAIN +
                                             int'(req.point_index));
    assign pt_wdata.freq = req.freq_mhz;
    assign pt_wdata.loss = req.loss_value;
    assign pt_rdata      = bpli_pkg::point_t'(pt_rword);

    // Read address is issued in the state before the one that uses the registered word
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  pt_raddr = req_base;
            ST_FIRST: pt_raddr = bpli_pkg::ADDR_W'(int'(base_reg) + int'(cnt_reg) - 1);
            ST_LAST:  pt_raddr = bpli_pkg::ADDR_W'(int'(base_reg) + 1);
            ST_SCAN:  pt_raddr = bpli_pkg::ADDR_W'(int'(base_reg) + int'(j_reg) + 1);
            default:  pt_raddr = base_reg;
        endcase
    end

    bpli_ram #(
        .WIDTH (bpli_pkg::POINT_W),
        .DEPTH (bpli_pkg::PT_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rword)
    );

    // Divider request and signed correction of its quotient
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = prod_reg[bpli_pkg::PROD_W-1] ? $unsigned(-prod_reg) :
                                                          $unsigned(prod_reg);
        div_req.divisor  = dden_reg;
        quo_mag    = div_rsp.quotient[bpli_pkg::DIFF_W-1:0];
        quo_signed = prod_reg[bpli_pkg::PROD_W-1] ? -$signed(quo_mag) : $signed(quo_mag);
        loss_sum   = $signed({prev_loss_reg[bpli_pkg::LOSS_W-1], prev_loss_reg}) + quo_signed;
    end

    bpli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Point counts and band port maps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bpli_pkg::CHAIN_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
            for (int i = 0; i < bpli_pkg::PMAP_DEPTH; i++)
            begin
                vsa_map_reg[i] <= bpli_pkg::PORT_RESET;
                vsg_map_reg[i] <= bpli_pkg::PORT_RESET;
            end
        end
        else if (req_fire && chain_ok)
        begin
            if (req.command == bpli_pkg::CMD_SET_COUNT)
            begin
                count_reg[chain_idx] <= sat_count;
            end
            if ((req.command == bpli_pkg::CMD_WRITE_PORTS) &&
                (int'(req.band) < bpli_pkg::BAND_COUNT))
            begin
                vsa_map_reg[wr_pmap_idx] <= req.vsa_port;
                vsg_map_reg[wr_pmap_idx] <= req.vsg_port;
            end
        end
    end

    // Lookup sequencer
    always_comb
    begin
        state_next     = state_reg;
        freq_next      = freq_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        prev_freq_next = prev_freq_reg;
        prev_loss_next = prev_loss_reg;
        df_next        = df_reg;
        dden_next      = dden_reg;
        dl_next        = dl_reg;
        prod_next      = prod_reg;
        loss_res_next  = loss_res_reg;
        vsa_res_next   = vsa_res_reg;
        vsg_res_next   = vsg_res_reg;
        hit_res_next   = hit_res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_loss_next  = out_loss_reg;
        out_vsa_next   = out_vsa_reg;
        out_vsg_next   = out_vsg_reg;
        out_hit_next   = out_hit_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.command == bpli_pkg::CMD_LOOKUP))
                begin
                    freq_next     = req.freq_mhz;
                    base_next     = req_base;
                    loss_res_next = bpli_pkg::LOSS_ONE;
                    if (chain_ok)
                    begin
                        cnt_next     = count_reg[chain_idx];
                        hit_res_next = band_hit;
                        vsa_res_next = band_hit ? vsa_map_reg[rd_pmap_idx] : '0;
                        vsg_res_next = band_hit ? vsg_map_reg[rd_pmap_idx] : '0;
                        state_next   = (count_reg[chain_idx] == '0) ? ST_FINISH : ST_FIRST;
                    end
                    else
                    begin
                        hit_res_next = 1'b0;
                        vsa_res_next = '0;
                        vsg_res_next = '0;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_FIRST:
            begin
                // Single point or at/below the first point
                if ((cnt_reg == bpli_pkg::CNT_W'(1)) || (freq_reg <= pt_rdata.freq))
                begin
                    loss_res_next = pt_rdata.loss;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    prev_freq_next = pt_rdata.freq;
                    prev_loss_next = pt_rdata.loss;
                    state_next     = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (freq_reg >= pt_rdata.freq)
                begin
                    loss_res_next = pt_rdata.loss;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    j_next     = bpli_pkg::CNT_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Compare against segment [j-1, j]
                if (freq_reg == prev_freq_reg)
                begin
                    loss_res_next = prev_loss_reg;
                    state_next    = ST_FINISH;
                end
                else if (freq_reg == pt_rdata.freq)
                begin
                    loss_res_next = pt_rdata.loss;
                    state_next    = ST_FINISH;
                end
                else if ((freq_reg > prev_freq_reg) && (freq_reg < pt_rdata.freq))
                begin
                    df_next    = freq_reg - prev_freq_reg;
                    dden_next  = pt_rdata.freq - prev_freq_reg;
                    dl_next    = $signed({pt_rdata.loss[bpli_pkg::LOSS_W-1], pt_rdata.loss}) -
                                 $signed({prev_loss_reg[bpli_pkg::LOSS_W-1], prev_loss_reg});
                    state_next = ST_MUL;
                end
                else if (j_reg == cnt_reg - 1'b1)
                begin
                    // Unsorted table with no matching segment
                    loss_res_next = '0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    prev_freq_next = pt_rdata.freq;
                    prev_loss_next = pt_rdata.loss;
                    j_next         = j_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next  = bpli_pkg::PROD_W'($signed({1'b0, df_reg})) *
                             bpli_pkg::PROD_W'(dl_reg);
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    loss_res_next = loss_sum[bpli_pkg::LOSS_W-1:0];
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_loss_next  = loss_res_reg;
                    out_vsa_next   = vsa_res_reg;
                    out_vsg_next   = vsg_res_reg;
                    out_hit_next   = hit_res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        freq_reg      <= freq_next;
        cnt_reg       <= cnt_next;
        j_reg         <= j_next;
        base_reg      <= base_next;
        prev_freq_reg <= prev_freq_next;
        prev_loss_reg <= prev_loss_next;
        df_reg        <= df_next;
        dden_reg      <= dden_next;
        dl_reg        <= dl_next;
        prod_reg      <= prod_next;
        loss_res_reg  <= loss_res_next;
        vsa_res_reg   <= vsa_res_next;
        vsg_res_reg   <= vsg_res_next;
        hit_res_reg   <= hit_res_next;
        out_loss_reg  <= out_loss_next;
        out_vsa_reg   <= out_vsa_next;
        out_vsg_reg   <= out_vsg_next;
        out_hit_reg   <= out_hit_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.loss_out = out_loss_reg;
    assign rsp.vsa_out  = out_vsa_reg;
    assign rsp.vsg_out  = out_vsg_reg;
    assign rsp.band_hit = out_hit_reg;

endmodule

// ----- hdl/bpli_checker.sv -----
// Port-level checks for the band port and loss interpolator, bound to the top.
// Depends on bpli_pkg and band_port_and_loss_interpolator.
`timescale 1ns / 1ps

module bpli_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic [bpli_pkg::CMD_W-1:0]         req_command,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic signed [bpli_pkg::LOSS_W-1:0] rsp_loss_out,
    input logic [bpli_pkg::PORT_W-1:0]        rsp_vsa_out,
    input logic [bpli_pkg::PORT_W-1:0]        rsp_vsg_out,
    input logic                               rsp_band_hit
);

    // Hold a stalled result transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transaction dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_loss_out) && $stable(rsp_vsa_out) &&
                                    $stable(rsp_vsg_out) && $stable(rsp_band_hit))
        else $error("stalled result payload changed");

    // A lookup busies the sequencer for at least the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == bpli_pkg::CMD_LOOKUP) |=> !req_ready)
        else $error("request taken while a lookup is running");

    // No band means no ports
    a_no_band_ports: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_band_hit |-> (rsp_vsa_out == '0) && (rsp_vsg_out == '0))
        else $error("ports reported outside any band");

endmodule

bind band_port_and_loss_interpolator bpli_checker u_bpli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_command  (req.command),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_loss_out (rsp.loss_out),
    .rsp_vsa_out  (rsp.vsa_out),
    .rsp_vsg_out  (rsp.vsg_out),
    .rsp_band_hit (rsp.band_hit)
);

// ----- tb/bpli_checker.sv -----
// Scoreboard for the band port and loss interpolator: watches both channels,
// predicts each lookup result from its own copy of the tables and compares.
// Depends on bpli_pkg and the channel interfaces in bpli_if.
`timescale 1ns / 1ps

module bpli_scoreboard
    import bpli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bpli_req_if  req,
    bpli_rsp_if  rsp,
    output int   mismatch_count,
    output int   lookups_open,
    output int   results_checked
);

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [PORT_W-1:0] vsa;
        logic [PORT_W-1:0] vsg;
        logic              hit;
    } lookup_result_t;

    // Shadow calibration tables and band port maps
    logic [FREQ_W-1:0] cal_freq [CHAIN_COUNT][POINTS_PER_CHAIN];
    logic [LOSS_W-1:0] cal_loss [CHAIN_COUNT][POINTS_PER_CHAIN];
    int                cal_count [CHAIN_COUNT];
    logic [PORT_W-1:0] vsa_map [CHAIN_COUNT][BAND_COUNT];
    logic [PORT_W-1:0] vsg_map [CHAIN_COUNT][BAND_COUNT];

    lookup_result_t expected_q [$];
    int             errors;
    int             compared;

    // Piecewise-linear loss at frequency f for chain c, Q8.8
    function automatic logic [LOSS_W-1:0] table_loss_at(int c, longint f);
        int     n;
        int     i;
        longint f0, f1, l0, l1;
        n = cal_count[c];
        if (n == 0)
            return LOSS_ONE;
        if (n == 1 || f <= longint'(cal_freq[c][0]))
            return cal_loss[c][0];
        if (f >= longint'(cal_freq[c][n-1]))
            return cal_loss[c][n-1];
        for (i = 1; i < n; i++)
        begin
            f0 = cal_freq[c][i-1];
            f1 = cal_freq[c][i];
            l0 = $signed(cal_loss[c][i-1]);
            l1 = $signed(cal_loss[c][i]);
            if (f == f0)
                return cal_loss[c][i-1];
            if (f == f1)
                return cal_loss[c][i];
            // SystemVerilog integer division truncates toward zero
            if (f > f0 && f < f1)
                return LOSS_W'(l0 + ((f - f0) * (l1 - l0)) / (f1 - f0));
        end
        // unsorted table with no segment around f
        return '0;
    endfunction

    function automatic lookup_result_t predict_lookup(int c, logic [FREQ_W-1:0] f);
        lookup_result_t r;
        band_t          b;
        r.hit = 1'b1;
        b     = BAND_24G;
        if (f <= EDGE_24G_MHZ)
            b = BAND_24G;
        else if (f > EDGE_5G_LOW_MHZ && f < EDGE_6G_MHZ)
            b = BAND_5G;
        else if (f >= EDGE_6G_MHZ)
            b = BAND_6G;
        else
            r.hit = 1'b0;
        if (c >= CHAIN_COUNT)
        begin
            r.loss = LOSS_ONE;
            r.vsa  = '0;
            r.vsg  = '0;
            r.hit  = 1'b0;
            return r;
        end
        r.vsa  = r.hit ? vsa_map[c][b] : '0;
        r.vsg  = r.hit ? vsg_map[c][b] : '0;
        r.loss = table_loss_at(c, f);
        return r;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHAIN_COUNT; c++)
            begin
                cal_count[c] = 0;
                for (int b = 0; b < BAND_COUNT; b++)
                begin
                    vsa_map[c][b] = PORT_RESET;
                    vsg_map[c][b] = PORT_RESET;
                end
            end
            expected_q.delete();
            errors   = 0;
            compared = 0;
        end
        else
        begin
            // Retire results first: none can belong to a request taken at this edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: result with no lookup outstanding: loss %0d vsa %0d vsg %0d hit %0d",
                             $time, rsp.loss_out, rsp.vsa_out, rsp.vsg_out, rsp.band_hit);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("loss_out", $signed(want.loss), rsp.loss_out);
                    check_field("vsa_out", want.vsa, rsp.vsa_out);
                    check_field("vsg_out", want.vsg, rsp.vsg_out);
                    check_field("band_hit", want.hit, rsp.band_hit);
                    compared++;
                end
            end

            // Apply the accepted command to the shadow tables
            if (req.valid && req.ready)
            begin
                case (cmd_t'(req.command))
                    CMD_WRITE_POINT:
                        if (req.chain < CHAIN_COUNT && req.point_index < POINTS_PER_CHAIN)
                        begin
                            cal_freq[req.chain][req.point_index] = req.freq_mhz;
                            cal_loss[req.chain][req.point_index] = req.loss_value;
                        end
                    CMD_SET_COUNT:
                        if (req.chain < CHAIN_COUNT)
                            cal_count[req.chain] = (req.point_count > POINTS_PER_CHAIN) ?
                                                   POINTS_PER_CHAIN : int'(req.point_count);
                    CMD_WRITE_PORTS:
                        if (req.chain < CHAIN_COUNT && req.band < BAND_COUNT)
                        begin
                            vsa_map[req.chain][req.band] = req.vsa_port;
                            vsg_map[req.chain][req.band] = req.vsg_port;
                        end
                    CMD_LOOKUP:
                        expected_q = {expected_q, predict_lookup(req.chain, req.freq_mhz)};
                    default: ;
                endcase
            end
        end
        mismatch_count  <= errors;
        lookups_open    <= expected_q.size();
        results_checked <= compared;
    end

endmodule

// ----- tb/band_port_and_loss_interpolator_tb.sv -----
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
// Depends on bpli_pkg, bpli_if, the block under test and bpli_scoreboard.
`timescale 1ns / 1ps

module band_port_and_loss_interpolator_tb;
    import bpli_pkg::*;

    localparam int ITEM_TARGET  = 600;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_GAP      = 6;
    localparam int DRAIN_EVERY  = 200;
    localparam int BAND_INVALID = 3;
    localparam int FREQ_TOP     = (1 << FREQ_W) - 1;
    localparam int COUNT_TOP    = (1 << CNT_IN_W) - 1;

    typedef struct packed {
        cmd_t                command;
        logic [CHAIN_W-1:0]  chain;
        logic [IDX_W-1:0]    point_index;
        logic [CNT_IN_W-1:0] point_count;
        logic [BAND_W-1:0]   band;
        logic [FREQ_W-1:0]   freq;
        logic [LOSS_W-1:0]   loss;
        logic [PORT_W-1:0]   vsa;
        logic [PORT_W-1:0]   vsg;
    } cal_cmd_t;

    logic clk;
    logic rst_n;

    bpli_req_if req_ch();
    bpli_rsp_if rsp_ch();

    int mismatch_count;
    int lookups_open;
    int results_checked;

    band_port_and_loss_interpolator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bpli_scoreboard u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatch_count  (mismatch_count),
        .lookups_open    (lookups_open),
        .results_checked (results_checked)
    );

    // What the stimulus knows of each table, so lookups never read unwritten points
    int                        shadow_count [CHAIN_COUNT]                   = '{default: 0};
    logic [POINTS_PER_CHAIN-1:0] written    [CHAIN_COUNT]                   = '{default: '0};
    logic [FREQ_W-1:0]         shadow_freq  [CHAIN_COUNT][POINTS_PER_CHAIN] = '{default: '{default: '0}};

    int band_edges [8] = '{0, EDGE_24G_MHZ, EDGE_24G_MHZ + 1, EDGE_5G_LOW_MHZ,
                           EDGE_5G_LOW_MHZ + 1, EDGE_6G_MHZ - 1, EDGE_6G_MHZ, FREQ_TOP};

    int sent;
    int n_points;
    int n_counts;
    int n_ports;
    int n_lookups;
    int next_drain;
    int idle_cycles;
    bit quiet;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic cal_cmd_t random_cmd();
        cal_cmd_t it;
        it.command     = cmd_t'($urandom_range(0, 3));
        it.chain       = CHAIN_W'($urandom);
        it.point_index = IDX_W'($urandom);
        it.point_count = CNT_IN_W'($urandom);
        it.band        = BAND_W'($urandom);
        it.freq        = FREQ_W'($urandom);
        it.loss        = LOSS_W'($urandom);
        it.vsa         = PORT_W'($urandom);
        it.vsg         = PORT_W'($urandom);
        return it;
    endfunction

    // Builders: unused fields keep random content
    function automatic cal_cmd_t point_cmd(int c, int idx, int f, int l);
        cal_cmd_t it;
        it             = random_cmd();
        it.command     = CMD_WRITE_POINT;
        it.chain       = CHAIN_W'(c);
        it.point_index = IDX_W'(idx);
        it.freq        = FREQ_W'(f);
        it.loss        = LOSS_W'(l);
        return it;
    endfunction

    function automatic cal_cmd_t count_cmd(int c, int n);
        cal_cmd_t it;
        it             = random_cmd();
        it.command     = CMD_SET_COUNT;
        it.chain       = CHAIN_W'(c);
        it.point_count = CNT_IN_W'(n);
        return it;
    endfunction

    function automatic cal_cmd_t ports_cmd(int c, int b, int a, int g);
        cal_cmd_t it;
        it         = random_cmd();
        it.command = CMD_WRITE_PORTS;
        it.chain   = CHAIN_W'(c);
        it.band    = BAND_W'(b);
        it.vsa     = PORT_W'(a);
        it.vsg     = PORT_W'(g);
        return it;
    endfunction

    function automatic cal_cmd_t lookup_cmd(int c, int f);
        cal_cmd_t it;
        it         = random_cmd();
        it.command = CMD_LOOKUP;
        it.chain   = CHAIN_W'(c);
        it.freq    = FREQ_W'(f);
        return it;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_cmd(input cal_cmd_t cmd);
        int gap;
        int low;
        int need;
        logic [POINTS_PER_CHAIN-1:0] missing;
        if (cmd.command == CMD_LOOKUP)
        begin
            need    = (1 << shadow_count[cmd.chain]) - 1;
            missing = need[POINTS_PER_CHAIN-1:0] & ~written[cmd.chain];
            // fill the lowest hole instead of reading it
            if (missing != '0)
            begin
                low = 0;
                for (int i = POINTS_PER_CHAIN - 1; i >= 0; i--)
                    if (missing[i])
                        low = i;
                cmd.command     = CMD_WRITE_POINT;
                cmd.point_index = IDX_W'(low);
            end
        end

        quiet = (sent % 100) < 20;
        gap   = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.command     <= cmd.command;
        req_ch.chain       <= cmd.chain;
        req_ch.point_index <= cmd.point_index;
        req_ch.point_count <= cmd.point_count;
        req_ch.band        <= cmd.band;
        req_ch.freq_mhz    <= cmd.freq;
        req_ch.loss_value  <= cmd.loss;
        req_ch.vsa_port    <= cmd.vsa;
        req_ch.vsg_port    <= cmd.vsg;
        req_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);

        case (cmd.command)
            CMD_WRITE_POINT:
            begin
                written[cmd.chain][cmd.point_index]     = 1'b1;
                shadow_freq[cmd.chain][cmd.point_index] = cmd.freq;
                n_points++;
                sent++;
            end
            CMD_SET_COUNT:
            begin
                shadow_count[cmd.chain] = (cmd.point_count > POINTS_PER_CHAIN) ?
                                          POINTS_PER_CHAIN : int'(cmd.point_count);
                n_counts++;
                sent++;
            end
            CMD_WRITE_PORTS:
                if (cmd.band != BAND_INVALID)
                begin
                    n_ports++;
                    sent++;
                end
            default:
            begin
                n_lookups++;
                sent++;
            end
        endcase
    endtask

    // Load an ascending table on one chain, then query it
    task automatic run_table_sequence();
        int c;
        int n;
        int f;
        int i;
        int pick;
        int cnt;
        c = $urandom_range(0, CHAIN_COUNT - 1);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POINTS_PER_CHAIN) : $urandom_range(1, 5);
        f = $urandom_range(0, 4000);
        for (i = 0; i < n; i++)
        begin
            send_cmd(point_cmd(c, i, f, $urandom));
            f += $urandom_range(0, (FREQ_TOP - f) / (n - i));
        end
        if ($urandom_range(0, 1))
            send_cmd(ports_cmd(c, $urandom_range(0, BAND_INVALID), $urandom, $urandom));
        cnt = (n == POINTS_PER_CHAIN && $urandom_range(0, 1)) ?
              $urandom_range(POINTS_PER_CHAIN, COUNT_TOP) : n;
        send_cmd(count_cmd(c, cnt));

        repeat ($urandom_range(2, 8))
        begin
            pick = $urandom_range(0, 3);
            f    = $urandom_range(0, FREQ_TOP);
            if (pick == 1 && n > 0)
                f = shadow_freq[c][$urandom_range(0, n - 1)];
            else if (pick == 2 && n > 1)
            begin
                i = $urandom_range(1, n - 1);
                f = $urandom_range(shadow_freq[c][i], shadow_freq[c][i-1]);
            end
            else if (pick == 3)
                f = band_edges[$urandom_range(0, 7)];
            send_cmd(lookup_cmd(c, f));
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_WRITE_POINT;
        req_ch.chain       <= '0;
        req_ch.point_index <= '0;
        req_ch.point_count <= '0;
        req_ch.band        <= '0;
        req_ch.freq_mhz    <= '0;
        req_ch.loss_value  <= '0;
        req_ch.vsa_port    <= '0;
        req_ch.vsg_port    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty tables across every band edge, reset port values
        send_cmd(lookup_cmd(0, 0));
        send_cmd(lookup_cmd(1, FREQ_TOP));
        send_cmd(lookup_cmd(0, EDGE_24G_MHZ));
        send_cmd(lookup_cmd(0, EDGE_24G_MHZ + 1));
        send_cmd(lookup_cmd(0, EDGE_5G_LOW_MHZ));
        send_cmd(lookup_cmd(0, EDGE_5G_LOW_MHZ + 1));
        send_cmd(lookup_cmd(0, EDGE_6G_MHZ - 1));
        send_cmd(lookup_cmd(0, EDGE_6G_MHZ));

        // Port writes, including an ignored band selector
        send_cmd(ports_cmd(2, BAND_24G, 15, 0));
        send_cmd(ports_cmd(2, BAND_5G, 0, 15));
        send_cmd(ports_cmd(2, BAND_INVALID, 7, 7));

        // Three points with extreme losses
        send_cmd(point_cmd(2, 0, 2000, -32768));
        send_cmd(point_cmd(2, 1, 5000, 32767));
        send_cmd(point_cmd(2, 2, 6500, 0));

        // Single point, then below, exact, between and above
        send_cmd(count_cmd(2, 1));
        send_cmd(lookup_cmd(2, 5500));
        send_cmd(count_cmd(2, 3));
        send_cmd(lookup_cmd(2, 1000));
        send_cmd(lookup_cmd(2, 2000));
        send_cmd(lookup_cmd(2, 5000));
        send_cmd(lookup_cmd(2, 3500));
        send_cmd(lookup_cmd(2, 5750));
        send_cmd(lookup_cmd(2, 6500));
        send_cmd(lookup_cmd(2, FREQ_TOP));

        // Oversized count saturates
        send_cmd(count_cmd(3, COUNT_TOP));

        // Random part: mostly table sequences, some noise
        next_drain = DRAIN_EVERY;
        while (sent < ITEM_TARGET)
        begin
            if (sent >= next_drain)
            begin
                // hold the sender until every lookup has answered
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (lookups_open != 0);
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_cmd(random_cmd());
            else
                run_table_sequence();
        end
        req_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (lookups_open != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d point writes, %0d count updates, %0d port writes, %0d lookups;",
                 n_points, n_counts, n_ports, n_lookups);
        $display("%0d lookup results compared over all chains and band edges.", results_checked);
        if (mismatch_count == 0 && lookups_open == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
